[src/scanline_clearance_checker_macros.svh]
// Assertion macros for the scan-line clearance checker, used by scc_run_tracker.
`ifndef SCANLINE_CLEARANCE_CHECKER_MACROS_SVH
`define SCANLINE_CLEARANCE_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanline clearance checker: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanline clearance checker: next-cycle check failed");

`endif

[src/scc_pkg.sv]
// Shared types and constants for the scan-line clearance checker.
package scc_pkg;

    localparam int LABEL_W      = 16;
    localparam int LEN_W        = 13;
    localparam int ERR_W        = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    localparam int LABEL_BITS_DEFAULT = 16;
    localparam int MAX_LINE_DEFAULT   = 4096;

    localparam logic [LEN_W-1:0] STANDOFF_NONE  = '1;
    localparam logic [LEN_W-1:0] CLEARANCE_INIT = LEN_W'(2);
    localparam logic [ERR_W-1:0] ERR_MAX        = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CLEARANCE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND_LABEL = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [LABEL_W-1:0] label;
        logic               line_start;
    } pixel_stage_t;

endpackage

[src/scc_input_stage.sv]
// Input register for pixel requests, held while it is full and the tracker cannot advance.
module scc_input_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_stall,
    input  logic [scc_pkg::LABEL_W-1:0] pixel_label,
    input  logic                        line_start,
    input  logic                        advance,
    output scc_pkg::pixel_stage_t       stage
);
    import scc_pkg::*;

    logic               valid_reg;
    logic [LABEL_W-1:0] label_reg;
    logic               start_reg;

    assign pixel_stall = valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!pixel_stall)
        begin
            valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!pixel_stall && pixel_valid)
        begin
            label_reg <= pixel_label;
            start_reg <= line_start;
        end
    end

    assign stage.valid      = valid_reg;
    assign stage.label      = label_reg;
    assign stage.line_start = start_reg;

endmodule

[src/scc_run_tracker.sv]
`include "scanline_clearance_checker_macros.svh"
// Run tracking, gap check, configuration registers and result register.
module scc_run_tracker #(
    parameter int LABEL_BITS = scc_pkg::LABEL_BITS_DEFAULT,
    parameter int MAX_LINE   = scc_pkg::MAX_LINE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  scc_pkg::pixel_stage_t           stage,
    output logic                            advance,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            violation,
    output logic                            gap_closed,
    output logic [scc_pkg::LEN_W-1:0]       gap_length,
    output logic [scc_pkg::ERR_W-1:0]       error_total,
    output logic [scc_pkg::LEN_W-1:0]       min_standoff
);
    import scc_pkg::*;

    localparam int LB      = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
    localparam int RUN_CAP = (MAX_LINE < 8191) ? MAX_LINE : 8191;
    localparam logic [LEN_W-1:0] RUN_CAP_V = LEN_W'(RUN_CAP);

    logic [LEN_W-1:0]   clearance_reg;
    logic [LABEL_W-1:0] background_reg;

    logic [LB-1:0]    cur_label_reg, cur_label_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [LB-1:0]    prior_label_reg, prior_label_next;
    logic             prior_valid_reg, prior_valid_next;
    logic [LEN_W-1:0] run_count_reg, run_count_next;
    logic [ERR_W-1:0] error_count_reg, error_count_next;
    logic [LEN_W-1:0] standoff_reg, standoff_next;

    logic             res_valid_reg;
    logic             viol_reg, viol_next;
    logic             closed_reg, closed_next;
    logic [LEN_W-1:0] glen_reg, glen_next;

    logic          step;
    logic          cv;
    logic          pv;
    logic          change;
    logic [LB-1:0] pix;
    logic [LB-1:0] bg;

    assign advance   = !res_valid_reg || !result_stall;
    assign step      = stage.valid && advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        pix    = stage.label[LB-1:0];
        bg     = background_reg[LB-1:0];
        cv     = cur_valid_reg && !stage.line_start;
        pv     = prior_valid_reg && !stage.line_start;
        change = !cv || (cur_label_reg != pix);

        closed_next = change && cv && (cur_label_reg == bg) && (!pv || (prior_label_reg != pix));
        glen_next   = closed_next ? run_count_reg : '0;
        viol_next   = closed_next && (run_count_reg < clearance_reg);

        error_count_next = error_count_reg;
        if (viol_next && (error_count_reg != ERR_MAX))
        begin
            error_count_next = error_count_reg + ERR_W'(1);
        end

        standoff_next = standoff_reg;
        if (closed_next && (run_count_reg < standoff_reg))
        begin
            standoff_next = run_count_reg;
        end

        if (change)
        begin
            prior_label_next = cur_label_reg;
            prior_valid_next = cv;
            cur_label_next   = pix;
            cur_valid_next   = 1'b1;
            run_count_next   = LEN_W'(1);
        end
        else
        begin
            prior_label_next = prior_label_reg;
            prior_valid_next = pv;
            cur_label_next   = cur_label_reg;
            cur_valid_next   = cur_valid_reg;
            run_count_next   = (run_count_reg < RUN_CAP_V) ? run_count_reg + LEN_W'(1)
                                                           : run_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearance_reg   <= CLEARANCE_INIT;
            background_reg  <= '0;
            cur_label_reg   <= '0;
            cur_valid_reg   <= 1'b0;
            prior_label_reg <= '0;
            prior_valid_reg <= 1'b0;
            run_count_reg   <= '0;
            error_count_reg <= '0;
            standoff_reg    <= STANDOFF_NONE;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_CLEARANCE:    clearance_reg  <= cfg_data[LEN_W-1:0];
                    CFG_BACKGROUND_LABEL: background_reg <= cfg_data[LABEL_W-1:0];
                    default:              ;
                endcase
            end
            if (advance)
            begin
                res_valid_reg <= stage.valid;
            end
            if (step)
            begin
                cur_label_reg   <= cur_label_next;
                cur_valid_reg   <= cur_valid_next;
                prior_label_reg <= prior_label_next;
                prior_valid_reg <= prior_valid_next;
                run_count_reg   <= run_count_next;
                error_count_reg <= error_count_next;
                standoff_reg    <= standoff_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            viol_reg   <= viol_next;
            closed_reg <= closed_next;
            glen_reg   <= glen_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign violation    = viol_reg;
    assign gap_closed   = closed_reg;
    assign gap_length   = glen_reg;
    assign error_total  = error_count_reg;
    assign min_standoff = standoff_reg;

    `SCC_ASSERT_IMPL(a_viol_needs_gap, clk, rst_n, res_valid_reg && viol_reg, closed_reg)
    `SCC_ASSERT_IMPL(a_no_gap_zero_len, clk, rst_n, res_valid_reg && !closed_reg, glen_reg == '0)
    `SCC_ASSERT_IMPL(a_min_below_gap, clk, rst_n, res_valid_reg && closed_reg, standoff_reg <= glen_reg)
    `SCC_ASSERT_NEXT(a_err_monotonic, clk, rst_n, 1'b1, error_count_reg >= $past(error_count_reg))
    `SCC_ASSERT_NEXT(a_min_monotonic, clk, rst_n, 1'b1, standoff_reg <= $past(standoff_reg))

endmodule

[src/scanline_clearance_checker.sv]
// Top level of the scan-line clearance checker.
//
// Pixel channel: pixel_valid / pixel_stall carry one request of pixel_label and
// line_start; a request is taken at a clock edge with pixel_valid high and
// pixel_stall low. Set line_start on the first pixel of each scan line.
// Result channel: result_valid / result_stall carry violation, gap_closed,
// gap_length, error_total and min_standoff, one result per pixel request.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
// min_clearance, index 1 is background_label. cfg_ready is always high; write
// only while no pixel request is in flight.
// Pipeline: a request taken at a clock edge enters one input register, then
// passes through the run and gap logic into the result register. Throughput
// is one pixel per cycle while result_stall is low.
// Stall: while result_stall holds a result, the input register holds its
// request and pixel_stall rises only once that register is full.
// Reset (rst_n low, asynchronous): runs and labels are cleared, error_total
// goes to 0, min_standoff to 8191, min_clearance to 2, background_label to 0.
module scanline_clearance_checker #(
    parameter int LABEL_BITS = scc_pkg::LABEL_BITS_DEFAULT,
    parameter int MAX_LINE   = scc_pkg::MAX_LINE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [scc_pkg::LABEL_W-1:0]     pixel_label,
    input  logic                            line_start,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            violation,
    output logic                            gap_closed,
    output logic [scc_pkg::LEN_W-1:0]       gap_length,
    output logic [scc_pkg::ERR_W-1:0]       error_total,
    output logic [scc_pkg::LEN_W-1:0]       min_standoff,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import scc_pkg::*;

    pixel_stage_t stage;
    logic         advance;

    scc_input_stage u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_label (pixel_label),
        .line_start  (line_start),
        .advance     (advance),
        .stage       (stage)
    );

    scc_run_tracker #(
        .LABEL_BITS (LABEL_BITS),
        .MAX_LINE   (MAX_LINE)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .advance      (advance),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .violation    (violation),
        .gap_closed   (gap_closed),
        .gap_length   (gap_length),
        .error_total  (error_total),
        .min_standoff (min_standoff)
    );

endmodule

[sim/tb_scanline_clearance_checker.sv]
// Self-checking testbench for the scan-line clearance checker, with a gap-tracking scoreboard.
module tb_scanline_clearance_checker;

    import scc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic             violation;
        logic             gap_closed;
        logic [LEN_W-1:0] gap_length;
        logic [ERR_W-1:0] error_total;
        logic [LEN_W-1:0] min_standoff;
    } gap_report_t;

    class clearance_scoreboard;
        localparam int RUN_CAP = (MAX_LINE_DEFAULT < 8191) ? MAX_LINE_DEFAULT : 8191;

        logic [LEN_W-1:0]   clearance;
        logic [LABEL_W-1:0] background;
        logic [LABEL_W-1:0] open_label;
        logic               open_valid;
        logic [LABEL_W-1:0] before_label;
        logic               before_valid;
        logic [LEN_W-1:0]   run_len;
        logic [ERR_W-1:0]   violations;
        logic [LEN_W-1:0]   nearest;
        gap_report_t        expected_reports[$];
        int                 failures;

        function new();
            clearance    = CLEARANCE_INIT;
            background   = '0;
            open_label   = '0;
            open_valid   = 1'b0;
            before_label = '0;
            before_valid = 1'b0;
            run_len      = '0;
            violations   = '0;
            nearest      = STANDOFF_NONE;
            failures     = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_MIN_CLEARANCE)
                clearance = data[LEN_W-1:0];
            else if (index == CFG_BACKGROUND_LABEL)
                background = data[LABEL_W-1:0];
        endfunction

        function void take_pixel(logic [LABEL_W-1:0] label, logic start);
            gap_report_t r;
            r = '0;
            if (start)
            begin
                open_valid   = 1'b0;
                before_valid = 1'b0;
            end
            if (!open_valid || open_label != label)
            begin
                if (open_valid && open_label == background &&
                    (!before_valid || before_label != label))
                begin
                    r.gap_closed = 1'b1;
                    r.gap_length = run_len;
                    if (run_len < clearance)
                    begin
                        r.violation = 1'b1;
                        if (violations != ERR_MAX)
                            violations++;
                    end
                    if (run_len < nearest)
                        nearest = run_len;
                end
                before_label = open_label;
                before_valid = open_valid;
                open_label   = label;
                open_valid   = 1'b1;
                run_len      = '0;
            end
            if (run_len < RUN_CAP)
                run_len++;
            r.error_total  = violations;
            r.min_standoff = nearest;
            expected_reports.push_back(r);
        endfunction

        function void check_result(gap_report_t got);
            gap_report_t want;
            if (expected_reports.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result with no request outstanding: %p", got);
                return;
            end
            want = expected_reports.pop_front();
            if (got.violation !== want.violation || got.gap_closed !== want.gap_closed ||
                got.gap_length !== want.gap_length || got.error_total !== want.error_total ||
                got.min_standoff !== want.min_standoff)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $write("result error: expected viol=%0d gap=%0d len=%0d err=%0d min=%0d",
                           want.violation, want.gap_closed, want.gap_length,
                           want.error_total, want.min_standoff);
                    $display(", got viol=%0d gap=%0d len=%0d err=%0d min=%0d",
                             got.violation, got.gap_closed, got.gap_length,
                             got.error_total, got.min_standoff);
                end
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pixel_valid = 1'b0;
    logic                   pixel_stall;
    logic [LABEL_W-1:0]     pixel_label = '0;
    logic                   line_start = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   violation;
    logic                   gap_closed;
    logic [LEN_W-1:0]       gap_length;
    logic [ERR_W-1:0]       error_total;
    logic [LEN_W-1:0]       min_standoff;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_MIN_CLEARANCE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    clearance_scoreboard sb;
    int                  burst_left = 0;
    bit                  quiet_sender = 1'b0;
    int                  pixels_sent = 0;

    scanline_clearance_checker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_label  (pixel_label),
        .line_start   (line_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .violation    (violation),
        .gap_closed   (gap_closed),
        .gap_length   (gap_length),
        .error_total  (error_total),
        .min_standoff (min_standoff),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic send_pixel(input logic [LABEL_W-1:0] label, input logic start);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = (quiet_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pixel_valid <= 1'b1;
        pixel_label <= label;
        line_start  <= start;
        do @(posedge clk); while (pixel_stall);
        sb.take_pixel(label, start);
        pixels_sent++;
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic configure(input logic [LEN_W-1:0] clearance,
                             input logic [LABEL_W-1:0] background);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MIN_CLEARANCE;
        cfg_data  <= CFG_DATA_W'(clearance);
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(CFG_MIN_CLEARANCE, CFG_DATA_W'(clearance));
        cfg_index <= CFG_BACKGROUND_LABEL;
        cfg_data  <= background;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(CFG_BACKGROUND_LABEL, background);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_pixel(16'h0005, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0007, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0007, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0001, 1'b1);
        send_pixel(16'h0001, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hAAAA, 1'b0);
        send_pixel(16'h5555, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h5555, 1'b0);
        send_pixel(16'h7FFF, 1'b0);
    endtask

    task automatic send_scanline();
        logic [LABEL_W-1:0] nets[4];
        logic [LABEL_W-1:0] label;
        logic               first;
        bit                 bg_turn;
        int                 runs;
        int                 len;
        int                 span;
        int                 r;
        int                 k;
        for (k = 0; k < 4; k++)
            nets[k] = ($urandom_range(0, 3) == 0) ? LABEL_W'($urandom) :
                                                    LABEL_W'($urandom_range(1, 8));
        span = (sb.clearance < 10) ? sb.clearance + 2 : 6;
        runs = $urandom_range(1, 8);
        first = 1'b1;
        bg_turn = 1'($urandom_range(0, 1));
        for (r = 0; r < runs; r++)
        begin
            label = bg_turn ? sb.background : nets[$urandom_range(0, 3)];
            len = $urandom_range(1, span);
            for (k = 0; k < len; k++)
            begin
                // break the line now and then
                send_pixel(label, first || ($urandom_range(0, 63) == 0));
                first = 1'b0;
            end
            bg_turn = !bg_turn;
        end
    endtask

    task automatic run_random(input int count);
        int target;
        int k;
        target = pixels_sent + count;
        quiet_sender = ($urandom_range(0, 2) == 0);
        while (pixels_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                for (k = $urandom_range(1, 5); k > 0; k--)
                    send_pixel(LABEL_W'($urandom), 1'($urandom_range(0, 1)));
            end
            else
                send_scanline();
        end
        quiet_sender = 1'b0;
    endtask

    initial
    begin : result_sink
        int unsigned cycle_count;
        int unsigned mode;
        int unsigned hold_left;
        cycle_count = 0;
        mode = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            // hold off long enough to back the block up
            if (cycle_count % 1000 == 300)
                hold_left = 90;
            if (cycle_count % 256 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= (cycle_count % 5 < 3);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result('{violation, gap_closed, gap_length, error_total, min_standoff});
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet == WATCHDOG_LIMIT)
            begin
                $display("scanline_clearance_checker: mismatch");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain();
        configure(LEN_W'(0), 16'hFFFF);
        run_random(150);
        drain();
        configure(LEN_W'(4096), 16'h0000);
        run_random(100);
        drain();
        configure(LEN_W'(1), LABEL_W'($urandom));
        run_random(150);
        drain();
        configure(LEN_W'($urandom_range(2, 8)), LABEL_W'($urandom_range(0, 8)));
        run_random(150);
        drain();
        configure(LEN_W'(3), 16'h0000);
        run_random(150);
        drain();
        configure(CLEARANCE_INIT, 16'h0000);
        run_random(50);
        drain();
        configure(LEN_W'($urandom_range(0, 4096)), LABEL_W'($urandom));
        run_random(100);
        drain();

        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("scanline_clearance_checker: match");
        else
            $display("scanline_clearance_checker: mismatch");
        $finish;
    end

endmodule
